/* src/aeob_pkg.sv */
// Shared types and constants for the accelerometer smoothing filter.
// No dependencies; aeob_tap_cell, aeob_mean_axis and the top level import this package.
`timescale 1ns / 1ps

package aeob_pkg;

	// One beat on the sample channel.
	typedef struct packed {
		logic signed [15:0] raw_x;
		logic signed [15:0] raw_y;
		logic signed [15:0] raw_z;
	} in_beat_t;

	// One beat on the result channel.
	typedef struct packed {
		logic signed [15:0] filtered_x;
		logic signed [15:0] filtered_y;
		logic signed [15:0] filtered_z;
	} out_beat_t;

	typedef enum logic [3:0] {
		REG_EMA_WEIGHT = 4'd0,
		REG_OFFSET_X   = 4'd1,
		REG_OFFSET_Y   = 4'd2,
		REG_OFFSET_Z   = 4'd3
	} cfg_reg_t;

	// One beat on the configuration write channel.
	typedef struct packed {
		cfg_reg_t    reg_idx;
		logic [15:0] wdata;
	} cfg_beat_t;

	// One offset-corrected value per axis, as held in each tap of the window.
	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} axis3_t;

	// Stage advance strobes handed from the top-level control to each mean lane.
	typedef struct packed {
		logic adv_s2;
		logic adv_s3;
		logic adv_s4;
	} pipe_ctl_t;

	localparam logic [15:0]        EMA_WEIGHT_RST = 16'd655;
	localparam logic signed [15:0] OFFSET_X_RST   = 16'sd220;
	localparam logic signed [15:0] OFFSET_Y_RST   = -16'sd1500;
	localparam logic signed [15:0] OFFSET_Z_RST   = 16'sd3500;

endpackage

/* src/aeob_stream_if.sv */
// Valid/ready channel used for samples, results and configuration writes.
// Payload type is a parameter; beat types come from aeob_pkg.
`timescale 1ns / 1ps

interface aeob_stream_if #(
	parameter type beat_t = logic
) ();
	logic  valid;
	logic  ready;
	beat_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* src/aeob_ema_axis.sv */
// Per-axis exponential average in Q16.16 plus offset, truncated and wrapped to 16 bits.
// Self-contained; the top level instances one per axis.
`timescale 1ns / 1ps

module aeob_ema_axis (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic signed [15:0] raw,
	input  logic [15:0]        weight,
	input  logic signed [15:0] offset,
	output logic signed [15:0] value
);

	logic signed [31:0] smooth_q;
	logic signed [32:0] diff;
	logic signed [49:0] prod;
	logic signed [33:0] step;
	logic signed [34:0] avg_sum;
	logic signed [31:0] avg;
	logic signed [32:0] with_off;

	assign diff     = {raw[15], raw, 16'd0} - {smooth_q[31], smooth_q};
	assign prod     = $signed({1'b0, weight}) * diff;
	// arithmetic shift of the product is the floor divide by 2^16
	assign step     = prod[49:16];
	assign avg_sum  = {{3{smooth_q[31]}}, smooth_q} + {step[33], step};
	assign avg      = avg_sum[31:0];
	assign with_off = {avg[31], avg} + {offset[15], offset, 16'd0};
	// toward zero: bump the floored integer part when negative with a fraction
	assign value    = with_off[31:16] + {15'd0, with_off[32] & (|with_off[15:0])};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_q <= '0;
		end else if (en) begin
			smooth_q <= avg;
		end
	end

endmodule

/* src/aeob_tap_cell.sv */
// One tap of the boxcar window: holds the three axis values of one item
// and hands them to the next tap on every advance. Depends on aeob_pkg.
`timescale 1ns / 1ps

module aeob_tap_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  aeob_pkg::axis3_t d,
	output aeob_pkg::axis3_t q
);
	import aeob_pkg::*;

	axis3_t tap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= '0;
		end else if (en) begin
			tap_q <= d;
		end
	end

	assign q = tap_q;

endmodule

/* src/aeob_mean_axis.sv */
// Per-axis running total of the window and its mean, truncated toward zero.
// Divide by WINDOW is an exact reciprocal multiply. Depends on aeob_pkg.
`timescale 1ns / 1ps

module aeob_mean_axis #(
	parameter int WINDOW = 45
) (
	input  logic                clk,
	input  logic                arst_n,
	input  aeob_pkg::pipe_ctl_t ctl,
	input  logic signed [15:0]  fresh,
	input  logic signed [15:0]  oldest,
	output logic signed [15:0]  mean
);
	import aeob_pkg::*;

	localparam int SUM_W  = 16 + $clog2(WINDOW);
	localparam int SHIFT  = SUM_W + $clog2(WINDOW);
	localparam int MULT_W = SUM_W + 1;
	localparam int PROD_W = SUM_W + MULT_W;
	// ceil(2^SHIFT / WINDOW): exact floor quotient for every magnitude below 2^SUM_W
	localparam longint unsigned MULT = ((64'd1 << SHIFT) + WINDOW - 1) / WINDOW;
	localparam logic [MULT_W-1:0] MULT_K = MULT_W'(MULT);

	logic signed [SUM_W-1:0] sum_q;
	logic signed [SUM_W-1:0] sum_next;
	logic [SUM_W-1:0]        mag;
	logic [PROD_W-1:0]       prod_s3;
	logic                    neg_s3;
	logic [15:0]             quo;
	logic signed [15:0]      mean_s4;

	assign sum_next = sum_q - SUM_W'(oldest) + SUM_W'(fresh);
	assign mag      = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign quo      = prod_s3[SHIFT +: 16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctl.adv_s2) begin
			sum_q <= sum_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv_s3) begin
			prod_s3 <= mag * MULT_K;
			neg_s3  <= sum_q[SUM_W-1];
		end
		if (ctl.adv_s4) begin
			mean_s4 <= neg_s3 ? -quo : quo;
		end
	end

	assign mean = mean_s4;

endmodule

/* src/accel_ema_offset_boxcar_filter_unit.sv */
// Top level of the accelerometer smoothing filter: EMA + offset, boxcar mean.
// Depends on aeob_pkg, aeob_stream_if, aeob_ema_axis, aeob_tap_cell, aeob_mean_axis.
//
//  channel  dir  payload                              beat taken when
//  sample   in   raw_x, raw_y, raw_z                  sample.valid & sample.ready
//  result   out  filtered_x, filtered_y, filtered_z   result.valid & result.ready
//  cfg      in   reg_idx, wdata                       cfg.valid (ready is tied high)
//
// One sample per cycle while result.ready is high; each is held in s1..s4 in turn.
// The rate is set by two feedback loops: the EMA update and the running window total.
// Stages s1..s4 each hold one beat with their own valid; a stalled result lets
// earlier stages keep filling, so up to four beats sit in flight.
// Reset is asynchronous and clears averages, totals and every window tap at once.
`timescale 1ns / 1ps

module accel_ema_offset_boxcar_filter_unit #(
	parameter int WINDOW = 45
) (
	input  logic          clk,
	input  logic          arst_n,
	aeob_stream_if.sink   sample,
	aeob_stream_if.source result,
	aeob_stream_if.sink   cfg
);
	import aeob_pkg::*;

	logic [15:0]        ema_weight_q;
	logic signed [15:0] offset_x_q;
	logic signed [15:0] offset_y_q;
	logic signed [15:0] offset_z_q;

	logic      valid_s1, valid_s2, valid_s3, valid_s4;
	logic      ready2, ready3, ready4;
	logic      sample_acc;
	pipe_ctl_t ctl;
	axis3_t    v_next;
	axis3_t    v_s1;
	axis3_t    tap [WINDOW];
	axis3_t    oldest;
	axis3_t    mean;

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ema_weight_q <= EMA_WEIGHT_RST;
			offset_x_q   <= OFFSET_X_RST;
			offset_y_q   <= OFFSET_Y_RST;
			offset_z_q   <= OFFSET_Z_RST;
		end else if (cfg.valid) begin
			unique case (cfg.data.reg_idx)
				REG_EMA_WEIGHT: ema_weight_q <= cfg.data.wdata;
				REG_OFFSET_X:   offset_x_q   <= cfg.data.wdata;
				REG_OFFSET_Y:   offset_y_q   <= cfg.data.wdata;
				REG_OFFSET_Z:   offset_z_q   <= cfg.data.wdata;
				default: ;
			endcase
		end
	end

	// Pipeline control
	assign ready4       = !valid_s4 || result.ready;
	assign ready3       = !valid_s3 || ready4;
	assign ready2       = !valid_s2 || ready3;
	assign sample.ready = !valid_s1 || ready2;
	assign sample_acc   = sample.valid && sample.ready;

	assign ctl.adv_s2 = valid_s1 && ready2;
	assign ctl.adv_s3 = valid_s2 && ready3;
	assign ctl.adv_s4 = valid_s3 && ready4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= sample_acc || (valid_s1 && !ready2);
			valid_s2 <= ctl.adv_s2 || (valid_s2 && !ready3);
			valid_s3 <= ctl.adv_s3 || (valid_s3 && !ready4);
			valid_s4 <= ctl.adv_s4 || (valid_s4 && !result.ready);
		end
	end

	// s1: exponential average and offset
	aeob_ema_axis u_ema_x (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (sample_acc),
		.raw    (sample.data.raw_x),
		.weight (ema_weight_q),
		.offset (offset_x_q),
		.value  (v_next.x)
	);

	aeob_ema_axis u_ema_y (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (sample_acc),
		.raw    (sample.data.raw_y),
		.weight (ema_weight_q),
		.offset (offset_y_q),
		.value  (v_next.y)
	);

	aeob_ema_axis u_ema_z (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (sample_acc),
		.raw    (sample.data.raw_z),
		.weight (ema_weight_q),
		.offset (offset_z_q),
		.value  (v_next.z)
	);

	always_ff @(posedge clk) begin
		if (sample_acc) begin
			v_s1 <= v_next;
		end
	end

	// s2: window taps shift as the running totals take the new value
	for (genvar i = 0; i < WINDOW; i++) begin : g_tap
		if (i == 0) begin : g_head
			aeob_tap_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (ctl.adv_s2),
				.d      (v_s1),
				.q      (tap[i])
			);
		end else begin : g_body
			aeob_tap_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (ctl.adv_s2),
				.d      (tap[i-1]),
				.q      (tap[i])
			);
		end
	end

	assign oldest = tap[WINDOW-1];

	// s2..s4: totals, reciprocal multiply, signed quotient
	aeob_mean_axis #(.WINDOW(WINDOW)) u_mean_x (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.fresh  (v_s1.x),
		.oldest (oldest.x),
		.mean   (mean.x)
	);

	aeob_mean_axis #(.WINDOW(WINDOW)) u_mean_y (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.fresh  (v_s1.y),
		.oldest (oldest.y),
		.mean   (mean.y)
	);

	aeob_mean_axis #(.WINDOW(WINDOW)) u_mean_z (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.fresh  (v_s1.z),
		.oldest (oldest.z),
		.mean   (mean.z)
	);

	assign result.valid           = valid_s4;
	assign result.data.filtered_x = mean.x;
	assign result.data.filtered_y = mean.y;
	assign result.data.filtered_z = mean.z;

	// With every stage full and the result stalled, no sample may enter.
	a_full_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && valid_s3 && valid_s4 && !result.ready |-> !sample.ready)
		else $error("sample accepted with pipeline full");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		sample_acc |=> valid_s1)
		else $error("accepted sample missing from s1");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !ready2 |=> valid_s1 && $stable(v_s1))
		else $error("s1 beat lost while stalled");

	a_head_tap_loads: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.adv_s2 |=> tap[0] == $past(v_s1))
		else $error("head tap did not take the s1 value");

endmodule
